// File: sv/svu_pkg.sv
// ----------------------------------------------------------------------------
// Softmax vector unit package
// Shared payload types and fixed-point constants.
// ----------------------------------------------------------------------------
package svu_pkg;

   typedef struct packed {
      logic signed [15:0] logit;
      logic               final_element;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] probability;
      logic [5:0]  position;
      logic        truncated;
      logic        end_of_run;
   } rsp_payload_type;

   localparam int unsigned STORE_DEPTH = 64;
   localparam logic [16:0] LOG2E_Q16   = 17'd94548;
   localparam logic [31:0] LN2_Q32     = 32'd2977044472;

endpackage

// File: sv/softmax_vector_unit.sv
// ----------------------------------------------------------------------------
// Softmax vector unit
// Max-subtracted softmax over a vector of Q8.8 logits.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle and stored with their running maximum.
// A marked last element starts two passes over the stored elements. The
// exp pass, for each element, does a memory read, a multiply by log2e and
// a table lookup and shift, and accumulates the sum. The emit pass reads
// the stored value and then loads it into a restoring divider. When the
// divider is done, the result is held until the receiver takes it. The
// fraction table is built at elaboration. Elements past min(MAX_LEN, 64)
// are dropped and every result of that vector carries truncated. No item
// is taken during the passes.
module softmax_vector_unit #(
   parameter int MAX_LEN         = 64,
   parameter int EXP_TABLE_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  svu_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output svu_pkg::rsp_payload_type rsp_payload
);
   import svu_pkg::*;

   localparam int LEN_CAP = (MAX_LEN > 64) ? 64 : MAX_LEN;
   localparam int TIW     = $clog2(EXP_TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_LOAD, S_XREAD, S_XMUL, S_XLUT, S_DREAD, S_DLOAD, S_DIV, S_OUT
   } state_type;

   function automatic logic [16:0] frac_pow2(input int idx);
      logic [63:0] u, w, term, acc, r;
      begin
         u    = (64'(idx) * 64'd65536) / 64'(EXP_TABLE_DEPTH);
         w    = (u * 64'(LN2_Q32)) >> 16;
         term = 64'd1 << 32;
         acc  = term;
         for (int n = 1; n <= 9; n++) begin
            term = ((term * w) >> 32) / 64'(n);
            if (n % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
            else acc = acc + term;
         end
         r = (acc + 64'd32768) >> 16;
         frac_pow2 = (r > 64'd65536) ? 17'd65536 : r[16:0];
      end
   endfunction

   logic [16:0] exp_rom [EXP_TABLE_DEPTH];
   always_comb begin
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) exp_rom[i] = frac_pow2(i);
   end

   logic signed [15:0] logit_mem [STORE_DEPTH];
   logic [16:0]        exp_mem   [STORE_DEPTH];

   state_type          state_ff;
   logic [6:0]         count_ff;
   logic [5:0]         idx_ff;
   logic signed [15:0] max_ff;
   logic [23:0]        sum_ff;
   logic               ovf_ff;
   logic signed [15:0] lrd_ff;
   logic [16:0]        erd_ff;
   logic [33:0]        z_ff;
   logic [32:0]        rem_ff;
   logic [32:0]        quo_ff;
   logic [5:0]         bit_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic [16:0] d_w;
   logic [17:0] k_w;
   logic [TIW-1:0] ti_w;
   logic [16:0] e_w;
   logic [33:0] rem_sh_w;
   logic        req_fire;
   logic [15:0] prob_w;

   assign d_w      = 17'($signed({max_ff[15], max_ff}) - $signed({lrd_ff[15], lrd_ff}));
   assign k_w      = z_ff[33:16];
   assign ti_w     = TIW'((32'(z_ff[15:0]) * 32'(EXP_TABLE_DEPTH)) >> 16);
   assign e_w      = (k_w >= 18'd17) ? 17'd0 : (exp_rom[ti_w] >> k_w[4:0]);
   assign rem_sh_w = {rem_ff, quo_ff[32]};
   assign prob_w   = (quo_ff > 33'd65535) ? 16'hFFFF : quo_ff[15:0];
   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (req_fire && count_ff < 7'(LEN_CAP))
         logit_mem[count_ff[5:0]] <= req_payload.logit;
      lrd_ff <= logit_mem[idx_ff];
      erd_ff <= exp_mem[idx_ff];
      if (state_ff == S_XLUT) exp_mem[idx_ff] <= e_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         idx_ff       <= '0;
         max_ff       <= 16'sh8000;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_fire) begin
                  logic [6:0] n;
                  n = count_ff;
                  if (count_ff < 7'(LEN_CAP)) begin
                     n = count_ff + 7'd1;
                     if (req_payload.logit > max_ff) max_ff <= req_payload.logit;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  count_ff <= n;
                  if (req_payload.final_element) begin
                     idx_ff   <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_XREAD;
                  end
               end
            end
            S_XREAD: state_ff <= S_XMUL;
            S_XMUL: begin
               z_ff     <= 34'((51'(d_w) * 51'(LOG2E_Q16)) >> 8);
               state_ff <= S_XLUT;
            end
            S_XLUT: begin
               sum_ff <= sum_ff + 24'(e_w);
               if (7'(idx_ff) + 7'd1 == count_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_DREAD;
               end else begin
                  idx_ff   <= idx_ff + 6'd1;
                  state_ff <= S_XREAD;
               end
            end
            S_DREAD: state_ff <= S_DLOAD;
            S_DLOAD: begin
               quo_ff   <= {erd_ff, 16'd0};
               rem_ff   <= '0;
               bit_ff   <= 6'd33;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (rem_sh_w >= 34'(sum_ff)) begin
                  rem_ff <= 33'(rem_sh_w - 34'(sum_ff));
                  quo_ff <= {quo_ff[31:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh_w[32:0];
                  quo_ff <= {quo_ff[31:0], 1'b0};
               end
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd1) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.probability     <= prob_w;
                  rsp_ff.position        <= idx_ff;
                  rsp_ff.truncated       <= ovf_ff;
                  rsp_ff.end_of_run      <= (7'(idx_ff) + 7'd1 == count_ff);
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (7'(idx_ff) + 7'd1 == count_ff) begin
                     count_ff <= '0;
                     max_ff   <= 16'sh8000;
                     ovf_ff   <= 1'b0;
                     state_ff <= S_LOAD;
                  end else begin
                     idx_ff   <= idx_ff + 6'd1;
                     state_ff <= S_DREAD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !req_ready)
      else $error("input taken during a pass");
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT))
      else $error("result outside emit");
   a_sum_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (sum_ff != 24'd0))
      else $error("zero divisor");
`endif

endmodule

// File: tb/sv/softmax_vector_unit_test.sv
// ----------------------------------------------------------------------------
// Softmax vector unit testbench
// Drives vectors of Q8.8 logits through the valid/ready request channel and
// checks every probability transfer against a predictor of the fixed-point
// softmax, with random gaps on both channels.
// ----------------------------------------------------------------------------
module softmax_vector_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import svu_pkg::*;

   localparam int MAX_LEN         = 64;
   localparam int EXP_TABLE_DEPTH = 64;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   softmax_vector_unit #(
      .MAX_LEN(MAX_LEN),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Predictor state.
   logic signed [15:0] held_logits[MAX_LEN];
   int                 held_count;
   logic signed [15:0] peak_logit;
   logic               dropped_any;
   logic [16:0]        frac_table[EXP_TABLE_DEPTH];
   rsp_payload_type    expected_probs[$];

   int failures;
   int vectors_done;
   int results_seen;
   int truncated_seen;
   int saturated_seen;

   function automatic logic [16:0] frac_power(int unsigned idx);
      logic [63:0] u, w, term, acc, r;
      u = (64'(idx) * 64'd65536) / 64'(EXP_TABLE_DEPTH);
      w = (u * 64'(LN2_Q32)) >> 16;
      term = 64'd1 << 32;
      acc = term;
      for (int n = 1; n <= 9; n++) begin
         term = ((term * w) >> 32) / 64'(n);
         if (n % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      r = (acc + 64'd32768) >> 16;
      return (r > 64'd65536) ? 17'd65536 : r[16:0];
   endfunction

   function automatic logic [16:0] exp_of_gap(logic [15:0] gap);
      logic [63:0] z, k, idx;
      z = (64'(gap) * 64'(LOG2E_Q16)) >> 8;
      k = z >> 16;
      idx = ((z & 64'hFFFF) * 64'(EXP_TABLE_DEPTH)) >> 16;
      if (k >= 17) begin
         return 17'd0;
      end
      return frac_table[idx] >> k;
   endfunction

   task automatic predict_softmax(input req_payload_type item);
      logic [16:0]     exps[MAX_LEN];
      logic [23:0]     total;
      logic [63:0]     p;
      rsp_payload_type r;
      if (held_count < MAX_LEN) begin
         held_logits[held_count] = item.logit;
         if (item.logit > peak_logit) begin
            peak_logit = item.logit;
         end
         held_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (item.final_element) begin
         total = '0;
         for (int i = 0; i < held_count; i++) begin
            exps[i] = exp_of_gap(16'(32'(peak_logit) - 32'(held_logits[i])));
            total = total + 24'(exps[i]);
         end
         for (int i = 0; i < held_count; i++) begin
            p = (total == 0) ? 64'd0 : (64'(exps[i]) << 16) / 64'(total);
            r.probability = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            r.position = 6'(i);
            r.truncated = dropped_any;
            r.end_of_run = (i + 1 == held_count);
            expected_probs = {expected_probs, r};
         end
         held_count = 0;
         peak_logit = 16'sh8000;
         dropped_any = 1'b0;
         vectors_done++;
      end
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 9) < 4) begin
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Checking of result transfers.
   rsp_payload_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_probs.size() == 0) begin
            $error("unexpected result: probability %0d position %0d",
               rsp_payload.probability, rsp_payload.position);
            failures++;
         end else begin
            want = expected_probs.pop_front();
            if (rsp_payload.probability == 16'hFFFF) begin
               saturated_seen++;
            end
            if (rsp_payload.truncated) begin
               truncated_seen++;
            end
            if (rsp_payload.probability !== want.probability) begin
               $error("probability: expected %0d, actual %0d",
                  want.probability, rsp_payload.probability);
               failures++;
            end
            if (rsp_payload.position !== want.position) begin
               $error("position: expected %0d, actual %0d",
                  want.position, rsp_payload.position);
               failures++;
            end
            if (rsp_payload.truncated !== want.truncated) begin
               $error("truncated: expected %0d, actual %0d",
                  want.truncated, rsp_payload.truncated);
               failures++;
            end
            if (rsp_payload.end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %0d, actual %0d",
                  want.end_of_run, rsp_payload.end_of_run);
               failures++;
            end
         end
      end
   end

   // Receiver with random stalls.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (1) begin
         stall = random_gap();
         rsp_ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1'b1;
         do @(negedge clock); while (!(rsp_valid && rsp_ready) && $urandom_range(0, 7) != 0);
      end
   end

   task automatic send_element(input logic signed [15:0] logit, input logic last);
      int gap;
      gap = random_gap();
      repeat (gap) @(negedge clock);
      req_payload.logit = logit;
      req_payload.final_element = last;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_softmax(req_payload);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   typedef struct {
      logic signed [15:0] logit;
      logic               last;
      logic [15:0]        known_prob;
      logic               has_known;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{16'sh7FFF, 1'b1, 16'hFFFF, 1'b1},
      '{16'sh8000, 1'b1, 16'hFFFF, 1'b1},
      '{16'sh0000, 1'b1, 16'hFFFF, 1'b1},
      '{16'sh8000, 1'b0, 16'h0000, 1'b1},
      '{16'sh7FFF, 1'b1, 16'hFFFF, 1'b1},
      '{16'sh0100, 1'b0, 16'h0000, 1'b0},
      '{16'sh0100, 1'b1, 16'h0000, 1'b0},
      '{16'shFF00, 1'b0, 16'h0000, 1'b0},
      '{16'sh0000, 1'b0, 16'h0000, 1'b0},
      '{16'sh0080, 1'b0, 16'h0000, 1'b0},
      '{16'sh5555, 1'b0, 16'h0000, 1'b0},
      '{16'shAAAA, 1'b1, 16'h0000, 1'b0}
   };

   initial begin
      int len, phase, sent, rmax;
      logic signed [15:0] base, v;
      int elapsed;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      failures = 0;
      vectors_done = 0;
      results_seen = 0;
      truncated_seen = 0;
      saturated_seen = 0;
      held_count = 0;
      peak_logit = 16'sh8000;
      dropped_any = 1'b0;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         frac_table[i] = frac_power(i);
      end
      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_element(directed_rows[i].logit, directed_rows[i].last);
         if (directed_rows[i].has_known && directed_rows[i].last &&
             expected_probs.size() > 0 &&
             expected_probs[expected_probs.size() - 1].probability !==
             directed_rows[i].known_prob) begin
            $error("probability: expected %0d, actual %0d", directed_rows[i].known_prob,
               expected_probs[expected_probs.size() - 1].probability);
            failures++;
         end
      end

      // Overlong vector: elements past MAX_LEN, the marked last one included,
      // are dropped.
      for (int i = 0; i < MAX_LEN + 3; i++) begin
         send_element(16'($urandom_range(0, 2047)) - 16'sd1024, i == MAX_LEN + 2);
      end

      sent = 0;
      while (sent < 170) begin
         phase = $urandom_range(0, 9);
         if (phase == 0) begin
            len = MAX_LEN + $urandom_range(1, 4);
         end else if (phase < 3) begin
            len = $urandom_range(1, 2);
         end else begin
            len = $urandom_range(2, 10);
         end
         rmax = (phase == 5) ? 65535 : 4095;
         base = 16'($urandom);
         for (int i = 0; i < len; i++) begin
            if (phase == 5) begin
               v = 16'($urandom);
            end else begin
               v = base + 16'($urandom_range(0, rmax)) - 16'(rmax / 2);
            end
            send_element(v, i == len - 1);
            sent++;
         end
      end

      elapsed = 0;
      while (expected_probs.size() != 0 && elapsed < 200000) begin
         @(posedge clock);
         elapsed++;
      end
      repeat (100) @(posedge clock);
      $display("Vectors %0d, results %0d, saturated %0d, truncated %0d.",
         vectors_done, results_seen, saturated_seen, truncated_seen);
      if (failures == 0 && expected_probs.size() == 0) begin
         $display("PASS softmax_vector_unit");
      end else begin
         $display("FAIL softmax_vector_unit");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL softmax_vector_unit");
      $finish;
   end

endmodule
